// ----- design/tclru_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile cache package
// Shared item types, operation codes and sequencer states.
// ----------------------------------------------------------------------------
package tclru_pkg;

  localparam int ZOOM_W = 5;
  localparam int COORD_W = 16;
  localparam int SLOT_W = 4;
  localparam int TAG_W = ZOOM_W + 2 * COORD_W;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_RECORD = 1'b1;

  typedef struct packed {
    logic               opcode;
    logic [ZOOM_W-1:0]  tile_zoom;
    logic [COORD_W-1:0] tile_col;
    logic [COORD_W-1:0] tile_row;
    logic [SLOT_W-1:0]  load_slot;
    logic               load_good;
  } in_item_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              data_ready;
    logic              need_load;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE
  } seq_state_t;

endpackage

// ----- design/tclru_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile cache RAM
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module tclru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/tile_cache_lru_lookup.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile cache LRU lookup
// Fully associative tag directory for map tiles with least-recently-used
// replacement, scanned one entry per cycle through a single compare unit.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: present in_item and raise start; the item is taken at an
//   edge where start is high and busy is low. busy stays high until the
//   sequencer is back in idle.
//   Result channel: out_strobe is high for exactly one cycle with out_item.
//   The receiver cannot stall it, so capture it on that cycle.
//   Config channel: cfg_data[0] is the cache enable, written on
//   cfg_valid & cfg_ready; cfg_ready is always high. Write only when idle.
// Timing:
//   A lookup reads the tag/stamp RAM at most once per valid entry. A miss
//   scans every valid entry, a hit stops at the matching entry, and a
//   lookup on an empty directory goes straight to the write; the result
//   strobe is registered from the write state. A record operation, or any
//   operation while disabled, gives its result in the cycle after accept
//   and busy never rises.
// Reset:
//   Synchronous active-low rst_n empties the directory (fill count zero),
//   clears the loaded flags and the access counter, and enables the cache.
//   Valid entries always form a prefix, so a fill count stands in for valid bits.
// ----------------------------------------------------------------------------
module tile_cache_lru_lookup
  import tclru_pkg::*;
#(
  parameter int ENTRIES = 16,
  parameter int STAMP_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_strobe,
  output out_item_t out_item,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int WORD_W = TAG_W + STAMP_BITS;

  seq_state_t state_r, state_nxt;

  logic [CNT_W-1:0]      fill_r, fill_nxt;
  logic [CNT_W-1:0]      addr_r, addr_nxt;
  logic [CNT_W-1:0]      rd_idx_r, rd_idx_nxt;
  logic                  rd_vld_r, rd_vld_nxt;
  logic [ENTRIES-1:0]    loaded_r, loaded_nxt;
  logic [STAMP_BITS-1:0] cnt_r, cnt_nxt;
  logic                  en_r, en_nxt;
  logic [TAG_W-1:0]      req_r, req_nxt;
  logic                  hit_r, hit_nxt;
  logic [IDX_W-1:0]      tgt_r, tgt_nxt;
  logic                  have_min_r, have_min_nxt;
  logic [STAMP_BITS-1:0] oldest_r, oldest_nxt;
  logic [IDX_W-1:0]      min_idx_r, min_idx_nxt;
  logic                  out_strobe_r, out_strobe_nxt;
  out_item_t             out_item_r, out_item_nxt;

  // RAM word: tag on top, stamp below
  logic                  ram_we;
  logic [WORD_W-1:0]     ram_wdata;
  logic [WORD_W-1:0]     ram_rdata;
  logic [TAG_W-1:0]      rd_tag;
  logic [STAMP_BITS-1:0] rd_stamp;
  logic [STAMP_BITS-1:0] cnt_inc;

  logic                  take_min;
  logic                  rd_last;
  logic [CNT_W+SLOT_W-1:0] ls_ext;
  logic [CNT_W+SLOT_W-1:0] fill_ext;
  logic [IDX_W+SLOT_W-1:0] slot_ext;

  assign rd_tag    = ram_rdata[WORD_W-1 -: TAG_W];
  assign rd_stamp  = ram_rdata[STAMP_BITS-1:0];
  assign cnt_inc   = cnt_r + STAMP_BITS'(1);
  assign ram_wdata = {req_r, cnt_inc};
  assign take_min  = !have_min_r || (rd_stamp < oldest_r);
  assign rd_last   = (rd_idx_r + CNT_W'(1)) == fill_r;
  assign ls_ext    = {{CNT_W{1'b0}}, in_item.load_slot};
  assign fill_ext  = {{SLOT_W{1'b0}}, fill_r};
  assign slot_ext  = {{SLOT_W{1'b0}}, tgt_r};

  tclru_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tgt_r),
    .wdata (ram_wdata),
    .raddr (addr_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  assign busy       = (state_r != S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  // Sequencer: next state, datapath updates and result
  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    addr_nxt       = addr_r;
    rd_idx_nxt     = addr_r;
    loaded_nxt     = loaded_r;
    cnt_nxt        = cnt_r;
    en_nxt         = en_r;
    req_nxt        = req_r;
    hit_nxt        = hit_r;
    tgt_nxt        = tgt_r;
    have_min_nxt   = have_min_r;
    oldest_nxt     = oldest_r;
    min_idx_nxt    = min_idx_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = '0;
    ram_we         = 1'b0;

    if (cfg_valid && cfg_ready) begin
      en_nxt = cfg_data;
    end

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt = {in_item.tile_zoom, in_item.tile_col, in_item.tile_row};
          // Disabled or record: all-zero result next cycle
          if (!en_r || in_item.opcode == OP_RECORD) begin
            out_strobe_nxt = 1'b1;
            if (en_r && ls_ext < fill_ext) begin
              loaded_nxt[ls_ext[IDX_W-1:0]] = in_item.load_good;
            end
          end else if (fill_r == '0) begin
            // Empty directory: claim entry zero straight away
            hit_nxt   = 1'b0;
            tgt_nxt   = '0;
            state_nxt = S_WRITE;
          end else begin
            addr_nxt     = '0;
            have_min_nxt = 1'b0;
            state_nxt    = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // Issue the next read while the previous one is compared
        if (addr_r < fill_r) begin
          addr_nxt = addr_r + CNT_W'(1);
        end
        if (rd_vld_r) begin
          if (rd_tag == req_r) begin
            hit_nxt   = 1'b1;
            tgt_nxt   = rd_idx_r[IDX_W-1:0];
            state_nxt = S_WRITE;
          end else begin
            if (take_min) begin
              have_min_nxt = 1'b1;
              oldest_nxt   = rd_stamp;
              min_idx_nxt  = rd_idx_r[IDX_W-1:0];
            end
            if (rd_last) begin
              hit_nxt = 1'b0;
              if (fill_r < CNT_W'(ENTRIES)) begin
                tgt_nxt = fill_r[IDX_W-1:0];
              end else if (take_min) begin
                tgt_nxt = rd_idx_r[IDX_W-1:0];
              end else begin
                tgt_nxt = min_idx_r;
              end
              state_nxt = S_WRITE;
            end
          end
        end
      end

      S_WRITE: begin
        // Stamp the entry; on a miss also write the tag and drop loaded
        ram_we  = 1'b1;
        cnt_nxt = cnt_inc;
        if (!hit_r) begin
          loaded_nxt[tgt_r] = 1'b0;
          if (CNT_W'(tgt_r) == fill_r) begin
            fill_nxt = fill_r + CNT_W'(1);
          end
        end
        out_strobe_nxt          = 1'b1;
        out_item_nxt.hit        = hit_r;
        out_item_nxt.slot       = slot_ext[SLOT_W-1:0];
        out_item_nxt.data_ready = hit_r && loaded_r[tgt_r];
        out_item_nxt.need_load  = !hit_r;
        state_nxt               = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    rd_vld_nxt = (state_r == S_SCAN) && (state_nxt == S_SCAN) && (addr_r < fill_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      fill_r       <= '0;
      addr_r       <= '0;
      rd_vld_r     <= 1'b0;
      loaded_r     <= '0;
      cnt_r        <= '0;
      en_r         <= 1'b1;
      have_min_r   <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fill_r       <= fill_nxt;
      addr_r       <= addr_nxt;
      rd_vld_r     <= rd_vld_nxt;
      loaded_r     <= loaded_nxt;
      cnt_r        <= cnt_nxt;
      en_r         <= en_nxt;
      have_min_r   <= have_min_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rd_idx_r   <= rd_idx_nxt;
    req_r      <= req_nxt;
    hit_r      <= hit_nxt;
    tgt_r      <= tgt_nxt;
    oldest_r   <= oldest_nxt;
    min_idx_r  <= min_idx_nxt;
    out_item_r <= out_item_nxt;
  end

  // Fill count never passes the directory size
  a_fill_bound : assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(ENTRIES))
    else $error("fill count exceeds entries");

  // Compared data always belongs to a valid entry
  a_rd_valid : assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (state_r == S_SCAN && rd_idx_r < fill_r))
    else $error("compare on an unused entry");

  // Every write cycle yields a result on the next cycle
  a_write_result : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WRITE |=> out_strobe)
    else $error("write without result");

  // Record and disabled items give an all-zero result in the next cycle, busy staying low
  a_quick_result : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (!en_r || in_item.opcode == OP_RECORD)) |=>
      (out_strobe && !busy && out_item == '0))
    else $error("quick item did not return a zero result");

  // A hit result never asks for a load
  a_result_kind : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !(out_item.hit && out_item.need_load))
    else $error("hit and load request together");

endmodule

// ----- dv/tile_cache_lru_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile cache LRU checker
// Watches the item, result and enable channels of the tile directory, keeps
// its own copy of the directory and compares every result with its forecast.
// ----------------------------------------------------------------------------
module tile_cache_lru_check
  import tclru_pkg::*;
#(
  parameter int ENTRIES = 16,
  parameter int STAMP_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  in_item_t  in_item,
  input  logic      out_strobe,
  input  out_item_t out_item,
  input  logic      cfg_valid,
  input  logic      cfg_ready,
  input  logic      cfg_data,
  output int        fault_count,
  output int        outcomes_due
);

  logic                  cache_on;
  logic                  line_valid  [ENTRIES];
  logic                  line_loaded [ENTRIES];
  logic [TAG_W-1:0]      line_tag    [ENTRIES];
  logic [STAMP_BITS-1:0] line_stamp  [ENTRIES];
  logic [STAMP_BITS-1:0] access_count;
  out_item_t             outcome_fifo[$];
  int                    faults = 0;

  // Apply one item to the directory copy and return the result it gives.
  function automatic out_item_t directory_step(in_item_t it);
    out_item_t             res;
    logic [TAG_W-1:0]      tag;
    int                    victim;
    int                    i;
    logic                  have_oldest;
    logic [STAMP_BITS-1:0] oldest;
    res = '0;
    tag = {it.tile_zoom, it.tile_col, it.tile_row};
    victim = 0;
    have_oldest = 1'b0;
    oldest = '0;
    if (!cache_on) return res;
    if (it.opcode == OP_RECORD) begin
      if (int'(it.load_slot) < ENTRIES && line_valid[it.load_slot])
        line_loaded[it.load_slot] = it.load_good;
      return res;
    end
    for (i = 0; i < ENTRIES; i++) begin
      if (line_valid[i] && line_tag[i] == tag) begin
        access_count = access_count + STAMP_BITS'(1);
        line_stamp[i] = access_count;
        res.hit = 1'b1;
        res.slot = SLOT_W'(i);
        res.data_ready = line_loaded[i];
        return res;
      end
      if (!line_valid[i]) begin
        victim = i;
        break;
      end
      // first holder of the smallest stamp wins
      if (!have_oldest || line_stamp[i] < oldest) begin
        have_oldest = 1'b1;
        oldest = line_stamp[i];
        victim = i;
      end
    end
    access_count = access_count + STAMP_BITS'(1);
    line_valid[victim] = 1'b1;
    line_loaded[victim] = 1'b0;
    line_tag[victim] = tag;
    line_stamp[victim] = access_count;
    res.slot = SLOT_W'(victim);
    res.need_load = 1'b1;
    return res;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      faults++;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    int        i;
    if (!rst_n) begin
      cache_on = 1'b1;
      access_count = '0;
      for (i = 0; i < ENTRIES; i++) begin
        line_valid[i] = 1'b0;
        line_loaded[i] = 1'b0;
      end
      outcome_fifo.delete();
    end else begin
      // compare before taking a new item, so a stray result never matches it
      if (out_strobe) begin
        if (outcome_fifo.size() == 0) begin
          $error("result with nothing pending: hit %0d slot %0d", out_item.hit,
                 out_item.slot);
          faults++;
        end else begin
          want = outcome_fifo.pop_front();
          check_field("hit", 32'(want.hit), 32'(out_item.hit));
          check_field("slot", 32'(want.slot), 32'(out_item.slot));
          check_field("data_ready", 32'(want.data_ready), 32'(out_item.data_ready));
          check_field("need_load", 32'(want.need_load), 32'(out_item.need_load));
        end
      end
      if (cfg_valid && cfg_ready) cache_on = cfg_data;
      if (start && !busy) outcome_fifo.push_back(directory_step(in_item));
    end
    fault_count  <= faults;
    outcomes_due <= outcome_fifo.size();
  end

endmodule

// ----- dv/tb_tile_cache_lru_lookup.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile cache LRU lookup testbench
// Drives directed and random tile lookups and load records into the tile
// directory, toggles the cache enable between phases, and leaves prediction
// and checking to the checker instance beside the block.
// ----------------------------------------------------------------------------
module tb_tile_cache_lru_lookup;
  import tclru_pkg::*;

  localparam int ENTRIES      = 16;
  localparam int POOL_N       = 24;     // more tags than entries, so evictions happen
  localparam int BATCHES      = 21;
  localparam int BATCH_ITEMS  = 55;
  localparam int OFF_ITEMS    = 20;     // shorter batches while the cache is off
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = ENTRIES + 8;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_strobe;
  out_item_t out_item;
  logic      cfg_valid;
  logic      cfg_ready;
  logic      cfg_data;

  int fault_count;
  int outcomes_due;
  int idle_pct;
  int cycles;

  // Tags the random lookups revisit, {zoom, col, row}
  logic [TAG_W-1:0] tag_pool [POOL_N];

  tile_cache_lru_lookup #(
    .ENTRIES   (ENTRIES),
    .STAMP_BITS(32)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  tile_cache_lru_check #(
    .ENTRIES   (ENTRIES),
    .STAMP_BITS(32)
  ) lru_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_item     (in_item),
    .out_strobe  (out_strobe),
    .out_item    (out_item),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .fault_count (fault_count),
    .outcomes_due(outcomes_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs or drops a result
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_tile_cache_lru_lookup NOT OK");
    $finish;
  end

  function automatic in_item_t mk(logic op, logic [ZOOM_W-1:0] z, logic [COORD_W-1:0] c,
                                  logic [COORD_W-1:0] r, logic [SLOT_W-1:0] s, logic g);
    in_item_t it;
    it.opcode    = op;
    it.tile_zoom = z;
    it.tile_col  = c;
    it.tile_row  = r;
    it.load_slot = s;
    it.load_good = g;
    return it;
  endfunction

  function automatic logic [TAG_W-1:0] random_tag();
    return {ZOOM_W'($urandom), COORD_W'($urandom), COORD_W'($urandom)};
  endfunction

  // Mostly lookups of pooled tags so hits and LRU evictions are common;
  // the rest are fresh tags and load records on random slots.
  function automatic in_item_t random_item();
    in_item_t it;
    it.opcode = ($urandom_range(99) < 25) ? OP_RECORD : OP_LOOKUP;
    {it.tile_zoom, it.tile_col, it.tile_row} =
      ($urandom_range(99) < 70) ? tag_pool[$urandom_range(POOL_N-1)] : random_tag();
    it.load_slot = SLOT_W'($urandom);
    it.load_good = 1'($urandom);
    return it;
  endfunction

  // Replace a few pool tags; half become one-bit neighbors of another tag
  // so that the compare must look at every tag bit.
  task automatic refresh_pool(input int n);
    int k;
    repeat (n) begin
      k = $urandom_range(POOL_N-1);
      if ($urandom_range(1))
        tag_pool[k] = tag_pool[$urandom_range(POOL_N-1)] ^
                      (TAG_W'(1) << $urandom_range(TAG_W-1));
      else
        tag_pool[k] = random_tag();
    end
  endtask

  // Idle at random, then hold start until the block takes the item.
  // Return at the edge that accepted it.
  task automatic send(input in_item_t it);
    logic [63:0] noise;
    while ($urandom_range(99) < idle_pct) begin
      noise = {$urandom, $urandom};
      start   <= 1'b0;
      in_item <= noise[$bits(in_item_t)-1:0];   // junk while start is low
      @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
  endtask

  // Drain all pending results, then write the enable register.
  task automatic write_enable(input logic v);
    start <= 1'b0;
    do @(posedge clk); while (outcomes_due != 0);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int b;
    int k;
    int n;
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_item   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= 1'b0;
    idle_pct  = 35;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: the cache comes out of reset enabled and empty.
    // Fill slots 0 and 1 with the all-zero and the all-ones tag, then hit the zero tag.
    send(mk(OP_LOOKUP, '0, '0, '0, '0, 1'b0));
    send(mk(OP_LOOKUP, '1, '1, '1, '0, 1'b0));
    send(mk(OP_LOOKUP, '0, '0, '0, '1, 1'b1));
    // Record a good load, then hit with data ready
    send(mk(OP_RECORD, '0, '0, '0, 4'd0, 1'b1));
    send(mk(OP_LOOKUP, '0, '0, '0, '0, 1'b0));
    // Record on an entry not yet in use: must be ignored
    send(mk(OP_RECORD, '1, '1, '1, 4'd15, 1'b1));
    send(mk(OP_RECORD, '0, '0, '0, 4'd1, 1'b0));
    send(mk(OP_LOOKUP, '1, '1, '1, '0, 1'b0));
    // Tags one field away from the zero tag must miss
    send(mk(OP_LOOKUP, 5'd1, '0, '0, '0, 1'b0));
    send(mk(OP_LOOKUP, '0, 16'd1, '0, '0, 1'b0));
    send(mk(OP_LOOKUP, '0, '0, 16'd1, '0, 1'b0));
    // Fill the remaining slots, then force LRU evictions on a full directory
    for (k = 5; k < ENTRIES; k++)
      send(mk(OP_LOOKUP, ZOOM_W'(k), COORD_W'(k), COORD_W'(k), '0, 1'b0));
    send(mk(OP_LOOKUP, 5'd20, 16'h1234, 16'h5678, '0, 1'b0));
    send(mk(OP_LOOKUP, '0, '0, '0, '0, 1'b0));
    send(mk(OP_RECORD, '1, '1, '1, 4'd3, 1'b1));

    // Cache off: results are all zero and nothing changes, records included
    write_enable(1'b0);
    send(mk(OP_LOOKUP, 5'd1, '0, '0, '0, 1'b0));
    send(mk(OP_RECORD, '0, '0, '0, 4'd2, 1'b1));
    write_enable(1'b1);
    send(mk(OP_LOOKUP, 5'd1, '0, '0, '0, 1'b0));

    // Random part: sender idles at 35, then 65, then never.
    // Every fifth batch runs with the cache off, the next one turns it back on.
    foreach (tag_pool[j]) tag_pool[j] = random_tag();
    for (b = 0; b < BATCHES; b++) begin
      idle_pct = (b < 7) ? 35 : (b < 14) ? 65 : 0;
      n = BATCH_ITEMS;
      if (b % 5 == 3) begin
        write_enable(1'b0);
        n = OFF_ITEMS;
      end else if (b % 5 == 4) begin
        write_enable(1'b1);
      end
      refresh_pool(4);
      repeat (n) send(random_item());
    end

    // Drop start, wait for the last result, then let the block settle
    start <= 1'b0;
    do @(posedge clk); while (outcomes_due != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0)
      $display("tb_tile_cache_lru_lookup OK");
    else
      $display("tb_tile_cache_lru_lookup NOT OK");
    $finish;
  end

endmodule
